// File: rtl/core/psa_pkg.sv
// Shared types and constants of the priority scheduler with aging.
// Holds the command and result words, the slot record and the aging settings.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psa_pkg;

    localparam logic       OP_ADD  = 1'b0;
    localparam logic       OP_TICK = 1'b1;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_ZERO      = 3'd2;
    localparam logic [2:0] ST_RAN       = 3'd3;
    localparam logic [2:0] ST_IDLE      = 3'd4;

    localparam logic [15:0] THRESHOLD_RST = 16'd10;
    localparam logic [7:0]  FLOOR_RST     = 8'd1;
    localparam logic [15:0] WAIT_MAX      = 16'hFFFF;
    localparam logic [4:0]  AGED_MAX      = 5'd31;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  task_priority;
        logic [15:0] task_burst;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] task_id;
        logic        finished;
        logic [15:0] remaining_burst;
        logic [4:0]  aged_count;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] wait_cnt;
        logic [15:0] remaining;
        logic [15:0] id;
    } t_slot_rec;

    typedef struct packed {
        logic [15:0] aging_threshold;
        logic [7:0]  priority_floor;
    } t_age_cfg;

endpackage

`default_nettype wire

// File: rtl/core/psa_slot_mem.sv
// Slot record memory: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psa_slot_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 60
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/psa_alu.sv
// Shared compare and aging unit, applied to one slot record per cycle.
// Depends on psa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psa_alu #(
    parameter int RANK_W = 4
) (
    input  wire psa_pkg::t_age_cfg  i_cfg,
    input  wire psa_pkg::t_slot_rec i_cur,
    input  wire logic [RANK_W-1:0]  i_cur_rank,
    input  wire psa_pkg::t_slot_rec i_best,
    input  wire logic [RANK_W-1:0]  i_best_rank,
    input  wire logic               i_drop,
    input  wire logic [RANK_W-1:0]  i_gone_rank,
    output logic                    o_better,
    output psa_pkg::t_slot_rec      o_next,
    output logic [RANK_W-1:0]       o_next_rank,
    output logic                    o_aged
);

    logic [15:0] w_wait_inc;

    always_comb begin
        priority if (i_cur.prio != i_best.prio) begin
            o_better = i_cur.prio < i_best.prio;
        end else if (i_cur.wait_cnt != i_best.wait_cnt) begin
            o_better = i_cur.wait_cnt > i_best.wait_cnt;
        end else begin
            o_better = i_cur_rank < i_best_rank;
        end
    end

    assign w_wait_inc = (i_cur.wait_cnt != psa_pkg::WAIT_MAX) ? i_cur.wait_cnt + 16'd1
                                                              : i_cur.wait_cnt;
    assign o_aged = (w_wait_inc >= i_cfg.aging_threshold)
                 && (i_cur.prio > i_cfg.priority_floor);

    always_comb begin
        o_next          = i_cur;
        o_next.wait_cnt = o_aged ? 16'd0 : w_wait_inc;
        o_next.prio     = o_aged ? i_cur.prio - 8'd1 : i_cur.prio;
        o_next_rank     = (i_drop && (i_cur_rank > i_gone_rank))
                        ? i_cur_rank - RANK_W'(1) : i_cur_rank;
    end

endmodule

`default_nettype wire

// File: rtl/core/psa_seq.sv
// Sequencer of the scheduler: walks the slot memory one slot per cycle
// for free-slot search, selection, the run step and aging.
// Depends on psa_pkg, psa_slot_mem and psa_alu.
`timescale 1ns / 1ps
`default_nettype none

module psa_seq #(
    parameter int TASK_SLOTS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire psa_pkg::t_age_cfg i_cfg,
    input  wire logic              i_start,
    input  wire psa_pkg::t_in_word i_cmd,
    output logic                   o_busy,
    output logic                   o_valid,
    output psa_pkg::t_out_word     o_result
);

    localparam int SW    = $clog2(TASK_SLOTS);
    localparam int CW    = $clog2(TASK_SLOTS + 1);
    localparam int REC_W = $bits(psa_pkg::t_slot_rec) + SW;
    localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);
    localparam logic [CW-1:0] FULL = CW'(TASK_SLOTS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_SEL    = 3'd2;
    localparam logic [2:0] S_PICK   = 3'd3;
    localparam logic [2:0] S_RUN_RD = 3'd4;
    localparam logic [2:0] S_RUN    = 3'd5;
    localparam logic [2:0] S_UPD    = 3'd6;

    logic [2:0]              r_state;
    psa_pkg::t_in_word       r_cmd;
    logic [TASK_SLOTS-1:0]   r_valid;
    logic [CW-1:0]           r_count;
    logic [15:0]             r_next_id;
    logic                    r_run_v;
    logic [SW-1:0]           r_run;
    logic [SW-1:0]           r_idx;
    logic                    r_issued;
    logic [SW-1:0]           r_pidx;
    logic                    r_pv;
    psa_pkg::t_slot_rec      r_best;
    logic [SW-1:0]           r_best_rank;
    logic [SW-1:0]           r_best_idx;
    logic                    r_bv;
    logic [SW-1:0]           r_gone_rank;
    logic                    r_fin;
    logic [4:0]              r_aged;
    psa_pkg::t_out_word      r_res;
    logic                    r_ovalid;

    logic [4:0]              n_aged;
    logic                    w_we;
    logic [SW-1:0]           w_waddr;
    logic [REC_W-1:0]        w_wdata;
    logic [SW-1:0]           w_raddr;
    logic [REC_W-1:0]        w_rdata;
    psa_pkg::t_slot_rec      w_cur;
    logic [SW-1:0]           w_cur_rank;
    psa_pkg::t_slot_rec      w_new;
    psa_pkg::t_slot_rec      w_ran;
    logic [15:0]             w_rem_dec;
    logic                    w_better;
    psa_pkg::t_slot_rec      w_aged_rec;
    logic [SW-1:0]           w_aged_rank;
    logic                    w_aged;
    logic                    w_upd_slot;
    logic                    w_walk_end;

    assign w_cur      = w_rdata[REC_W-1:SW];
    assign w_cur_rank = w_rdata[SW-1:0];
    assign w_rem_dec  = w_cur.remaining - 16'd1;
    assign w_upd_slot = r_pv && r_valid[r_pidx] && (r_pidx != r_run);
    assign w_walk_end = r_pv && (r_pidx == LAST);
    assign n_aged     = (w_upd_slot && w_aged && (r_aged != psa_pkg::AGED_MAX))
                      ? r_aged + 5'd1 : r_aged;

    always_comb begin
        w_new.prio      = r_cmd.task_priority;
        w_new.wait_cnt  = 16'd0;
        w_new.remaining = r_cmd.task_burst;
        w_new.id        = r_next_id;
        w_ran           = w_cur;
        w_ran.remaining = w_rem_dec;
    end

    always_comb begin
        w_raddr = (r_state == S_RUN_RD) ? r_run : r_idx;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = {w_new, r_count[SW-1:0]};
        unique case (r_state)
            S_FIND: begin
                w_we = !r_valid[r_idx];
            end
            S_RUN: begin
                w_we    = 1'b1;
                w_waddr = r_run;
                w_wdata = {w_ran, w_cur_rank};
            end
            S_UPD: begin
                w_we    = w_upd_slot;
                w_waddr = r_pidx;
                w_wdata = {w_aged_rec, w_aged_rank};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    psa_slot_mem #(
        .DEPTH  (TASK_SLOTS),
        .DATA_W (REC_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    psa_alu #(
        .RANK_W (SW)
    ) u_alu (
        .i_cfg       (i_cfg),
        .i_cur       (w_cur),
        .i_cur_rank  (w_cur_rank),
        .i_best      (r_best),
        .i_best_rank (r_best_rank),
        .i_drop      (r_fin),
        .i_gone_rank (r_gone_rank),
        .o_better    (w_better),
        .o_next      (w_aged_rec),
        .o_next_rank (w_aged_rank),
        .o_aged      (w_aged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_next_id <= 16'd1;
            r_run_v   <= 1'b0;
            r_run     <= '0;
            r_issued  <= 1'b0;
            r_pv      <= 1'b0;
            r_bv      <= 1'b0;
            r_fin     <= 1'b0;
            r_aged    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_ovalid <= 1'b0;
            if (r_state == S_SEL || r_state == S_UPD) begin
                if (!r_issued) begin
                    r_pidx <= r_idx;
                    r_pv   <= 1'b1;
                    if (r_idx == LAST) begin
                        r_issued <= 1'b1;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end else begin
                    r_pv <= 1'b0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.opcode == psa_pkg::OP_ADD) begin
                            priority if (i_cmd.task_burst == 16'd0) begin
                                r_res    <= '{status: psa_pkg::ST_ZERO, default: '0};
                                r_ovalid <= 1'b1;
                            end else if (r_count == FULL) begin
                                r_res    <= '{status: psa_pkg::ST_FULL, default: '0};
                                r_ovalid <= 1'b1;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_FIND;
                            end
                        end else if (r_run_v) begin
                            r_state <= S_RUN_RD;
                        end else begin
                            r_idx    <= '0;
                            r_issued <= 1'b0;
                            r_pv     <= 1'b0;
                            r_bv     <= 1'b0;
                            r_state  <= S_SEL;
                        end
                    end
                end
                S_FIND: begin
                    if (!r_valid[r_idx]) begin
                        r_valid[r_idx] <= 1'b1;
                        r_count        <= r_count + CW'(1);
                        r_res          <= '{status: psa_pkg::ST_ADDED, task_id: r_next_id,
                                            default: '0};
                        r_next_id      <= r_next_id + 16'd1;
                        r_ovalid       <= 1'b1;
                        r_state        <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                S_SEL: begin
                    if (r_pv && r_valid[r_pidx] && (!r_bv || w_better)) begin
                        r_best      <= w_cur;
                        r_best_rank <= w_cur_rank;
                        r_best_idx  <= r_pidx;
                        r_bv        <= 1'b1;
                    end
                    if (w_walk_end) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (r_bv) begin
                        r_run   <= r_best_idx;
                        r_run_v <= 1'b1;
                        r_state <= S_RUN_RD;
                    end else begin
                        r_res    <= '{status: psa_pkg::ST_IDLE, default: '0};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_RUN_RD: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_res.status          <= psa_pkg::ST_RAN;
                    r_res.task_id         <= w_cur.id;
                    r_res.remaining_burst <= w_rem_dec;
                    r_res.finished        <= (w_rem_dec == 16'd0);
                    r_fin                 <= (w_rem_dec == 16'd0);
                    r_gone_rank           <= w_cur_rank;
                    if (w_rem_dec == 16'd0) begin
                        r_valid[r_run] <= 1'b0;
                        r_count        <= r_count - CW'(1);
                        r_run_v        <= 1'b0;
                    end
                    r_idx    <= '0;
                    r_issued <= 1'b0;
                    r_pv     <= 1'b0;
                    r_aged   <= '0;
                    r_state  <= S_UPD;
                end
                S_UPD: begin
                    r_aged <= n_aged;
                    if (w_walk_end) begin
                        r_res.aged_count <= n_aged;
                        r_ovalid         <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_result = r_res;

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("fill count differs from valid bits");

    a_running_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_v |-> r_valid[r_run])
        else $error("running task slot is empty");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_valid))
        else $error("accepted word neither worked on nor answered");

    a_pick_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && r_bv) |-> r_valid[r_best_idx])
        else $error("selected slot is empty");

endmodule

`default_nettype wire

// File: rtl/core/priority_scheduler_with_aging.sv
// Top level of the nonpreemptive priority scheduler with aging.
// Holds the configuration registers; depends on psa_pkg and psa_seq.
//
// Usage:
//   Command channel: i_cmd is taken at a rising edge with start high and
//   busy low. opcode add stores a task, opcode tick runs one timer tick.
//   Result channel: every command gives exactly one word on o_result,
//   marked by o_valid for a single cycle; the receiver cannot stall it.
//   Configuration: APB writes at byte 0 (aging threshold) and byte 4
//   (priority floor); pready is tied high. The user must write only while
//   busy is low; the block itself does not enforce this.
// Steps: add with zero burst or full table gives its result in the cycle
//   after accept; add scans the slots in order for a free entry. A tick
//   walks the slot memory one slot per cycle, through one read port and one
//   write port: with a running task it runs it, then ages all other slots;
//   else it selects over all slots, then runs and ages, or answers idle.
// Throughput: one command at a time; busy drops in the strobe cycle, so
//   the next command can be taken at the edge that ends it.
// Reset: slot table empty, no task running, next id 1, threshold 10,
//   floor 1. Slot records are not cleared; only valid bits are.
`timescale 1ns / 1ps
`default_nettype none

module priority_scheduler_with_aging #(
    parameter int TASK_SLOTS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire psa_pkg::t_in_word  i_cmd,
    output logic                    o_valid,
    output psa_pkg::t_out_word      o_result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_FLOOR     = 1'b1;

    psa_pkg::t_age_cfg r_cfg;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.aging_threshold <= psa_pkg::THRESHOLD_RST;
            r_cfg.priority_floor  <= psa_pkg::FLOOR_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_THRESHOLD: r_cfg.aging_threshold <= pwdata[15:0];
                REG_FLOOR:     r_cfg.priority_floor  <= pwdata[7:0];
                default:       r_cfg                 <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_THRESHOLD: prdata = {16'd0, r_cfg.aging_threshold};
            REG_FLOOR:     prdata = {24'd0, r_cfg.priority_floor};
            default:       prdata = 32'd0;
        endcase
    end

    psa_seq #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// File: dv/priority_scheduler_with_aging_tb.sv
// Self-checking testbench of priority_scheduler_with_aging: directed table, then random words.
// Carries its own scheduler predictor and checks every result word, plus APB read-back.
// Depends on psa_pkg and the priority_scheduler_with_aging RTL.
`timescale 1ns / 1ps

module priority_scheduler_with_aging_tb;

    import psa_pkg::*;

    localparam int TASK_SLOTS   = 16;
    localparam int RANDOM_ITEMS = 1650;
    localparam int PHASE_ITEMS  = 220;
    localparam int DRAIN_CYCLES = 2 * TASK_SLOTS + 8;

    localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
    localparam logic [2:0] ADDR_FLOOR     = 3'd4;

    typedef struct packed {
        t_in_word  w;
        logic      typed;
        t_out_word res;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_word    i_cmd;
    logic        o_valid;
    t_out_word   o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic        slot_used     [TASK_SLOTS];
    logic [7:0]  slot_prio     [TASK_SLOTS];
    logic [15:0] slot_wait_cnt [TASK_SLOTS];
    logic [15:0] slot_left     [TASK_SLOTS];
    logic [15:0] slot_tag      [TASK_SLOTS];
    int          slot_rank     [TASK_SLOTS];
    logic        cpu_busy;
    int          cpu_slot;
    logic [15:0] id_next;
    logic [15:0] cfg_threshold;
    logic [7:0]  cfg_floor;

    t_out_word   pending_results [$];
    dir_row_t    dir_rows [$];

    int n_errors = 0;
    int n_sent   = 0;
    int n_added  = 0;
    int n_full   = 0;
    int n_zero   = 0;
    int n_ran    = 0;
    int n_done   = 0;
    int n_idle   = 0;
    int n_aged   = 0;
    int n_cfg    = 0;

    priority_scheduler_with_aging #(
        .TASK_SLOTS(TASK_SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        $display("mismatch at %0t ns: %s expected 0x%0h got 0x%0h", $time, what, exp_v, got_v);
        n_errors++;
    endtask

    function automatic void sched_reset();
        for (int i = 0; i < TASK_SLOTS; i++) begin
            slot_used[i]     = 1'b0;
            slot_prio[i]     = '0;
            slot_wait_cnt[i] = '0;
            slot_left[i]     = '0;
            slot_tag[i]      = '0;
            slot_rank[i]     = 0;
        end
        cpu_busy      = 1'b0;
        cpu_slot      = 0;
        id_next       = 16'd1;
        cfg_threshold = THRESHOLD_RST;
        cfg_floor     = FLOOR_RST;
    endfunction

    function automatic int tasks_held();
        int cnt;
        cnt = 0;
        for (int i = 0; i < TASK_SLOTS; i++)
            if (slot_used[i]) cnt++;
        return cnt;
    endfunction

    function automatic bit outranks(int a, int b);
        if (slot_prio[a] != slot_prio[b]) return slot_prio[a] < slot_prio[b];
        if (slot_wait_cnt[a] != slot_wait_cnt[b]) return slot_wait_cnt[a] > slot_wait_cnt[b];
        return slot_rank[a] < slot_rank[b];
    endfunction

    function automatic t_out_word sched_step(input t_in_word w);
        t_out_word res;
        int        free_idx;
        int        held;
        int        best;
        int        r;
        int        aged;
        res      = '0;
        free_idx = -1;
        held     = 0;
        best     = -1;
        aged     = 0;
        if (w.opcode == OP_ADD) begin
            if (w.task_burst == 16'd0) begin
                res.status = ST_ZERO;
                return res;
            end
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (slot_used[i]) held++;
                else if (free_idx < 0) free_idx = i;
            end
            if (free_idx < 0) begin
                res.status = ST_FULL;
                return res;
            end
            slot_used[free_idx]     = 1'b1;
            slot_prio[free_idx]     = w.task_priority;
            slot_wait_cnt[free_idx] = 16'd0;
            slot_left[free_idx]     = w.task_burst;
            slot_tag[free_idx]      = id_next;
            slot_rank[free_idx]     = held;
            res.status  = ST_ADDED;
            res.task_id = id_next;
            id_next     = id_next + 16'd1;
            return res;
        end
        if (!cpu_busy || !slot_used[cpu_slot]) begin
            cpu_busy = 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++)
                if (slot_used[i] && (best < 0 || outranks(i, best))) best = i;
            if (best < 0) begin
                res.status = ST_IDLE;
                return res;
            end
            cpu_busy = 1'b1;
            cpu_slot = best;
        end
        r = cpu_slot;
        slot_left[r]        = slot_left[r] - 16'd1;
        res.status          = ST_RAN;
        res.task_id         = slot_tag[r];
        res.remaining_burst = slot_left[r];
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (slot_used[i] && i != r) begin
                if (slot_wait_cnt[i] != WAIT_MAX) slot_wait_cnt[i] = slot_wait_cnt[i] + 16'd1;
                if (slot_wait_cnt[i] >= cfg_threshold && slot_prio[i] > cfg_floor) begin
                    slot_prio[i]     = slot_prio[i] - 8'd1;
                    slot_wait_cnt[i] = 16'd0;
                    aged++;
                end
            end
        end
        res.aged_count = (aged > 31) ? AGED_MAX : aged[4:0];
        if (slot_left[r] == 16'd0) begin
            res.finished = 1'b1;
            slot_used[r] = 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++)
                if (slot_used[i] && slot_rank[i] > slot_rank[r]) slot_rank[i]--;
            cpu_busy = 1'b0;
        end
        return res;
    endfunction

    function automatic dir_row_t dir_entry(input logic op, input logic [7:0] p,
                                           input logic [15:0] b, input logic typed,
                                           input logic [2:0] st, input logic [15:0] id,
                                           input logic fin, input logic [15:0] rem);
        dir_row_t e;
        e.w.opcode            = op;
        e.w.task_priority     = p;
        e.w.task_burst        = b;
        e.typed               = typed;
        e.res.status          = st;
        e.res.task_id         = id;
        e.res.finished        = fin;
        e.res.remaining_burst = rem;
        e.res.aged_count      = '0;
        return e;
    endfunction

    function automatic t_in_word make_add();
        t_in_word w;
        int       pick;
        w.opcode = OP_ADD;
        pick = $urandom_range(0, 3);
        if (pick == 0) w.task_priority = 8'($urandom_range(0, 7));
        else if (pick == 1) w.task_priority = cfg_floor + 8'($urandom_range(0, 3));
        else w.task_priority = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 19);
        if (tasks_held() == TASK_SLOTS) w.task_burst = 16'($urandom_range(0, 65535));
        else if (pick == 0) w.task_burst = 16'd0;
        else if (pick < 3) w.task_burst = 16'($urandom_range(4, 12));
        else w.task_burst = 16'($urandom_range(1, 3));
        return w;
    endfunction

    task automatic send_word(input t_in_word w, input int gap, input logic typed,
                             input t_out_word typed_res);
        t_out_word want;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        want = sched_step(w);
        pending_results.push_back(typed ? typed_res : want);
        n_sent++;
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_aging(input logic [15:0] thr, input logic [7:0] flr);
        logic [31:0] rd;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        apb_write(ADDR_THRESHOLD, {16'd0, thr});
        apb_write(ADDR_FLOOR, {24'd0, flr});
        apb_read(ADDR_THRESHOLD, rd);
        if (rd !== {16'd0, thr}) report_mismatch("aging_threshold read-back", thr, rd);
        apb_read(ADDR_FLOOR, rd);
        if (rd !== {24'd0, flr}) report_mismatch("priority_floor read-back", flr, rd);
        cfg_threshold = thr;
        cfg_floor     = flr;
        n_cfg++;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("status of unexpected word", 0, o_result.status);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", want.status, o_result.status);
                if (o_result.task_id !== want.task_id)
                    report_mismatch("task_id", want.task_id, o_result.task_id);
                if (o_result.finished !== want.finished)
                    report_mismatch("finished", want.finished, o_result.finished);
                if (o_result.remaining_burst !== want.remaining_burst)
                    report_mismatch("remaining_burst", want.remaining_burst,
                                    o_result.remaining_burst);
                if (o_result.aged_count !== want.aged_count)
                    report_mismatch("aged_count", want.aged_count, o_result.aged_count);
                case (want.status)
                    ST_ADDED: n_added++;
                    ST_FULL:  n_full++;
                    ST_ZERO:  n_zero++;
                    ST_RAN:   n_ran++;
                    default:  n_idle++;
                endcase
                if (want.finished) n_done++;
                n_aged += want.aged_count;
            end
        end
    end

    initial begin
        t_in_word w;
        int       k;
        int       len;
        int       kind;
        int       gap_max;
        int       phase;
        int       next_cfg;
        int       n_random;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sched_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: empty table, zero burst, extremes of priority, ties on priority
        dir_rows.push_back(dir_entry(OP_TICK, 8'd0,   16'd0, 1'b1, ST_IDLE,  16'd0, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_ADD,  8'd5,   16'd0, 1'b1, ST_ZERO,  16'd0, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_ADD,  8'd0,   16'd1, 1'b1, ST_ADDED, 16'd1, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_ADD,  8'd255, 16'd2, 1'b1, ST_ADDED, 16'd2, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_TICK, 8'd0,   16'd0, 1'b1, ST_RAN,   16'd1, 1'b1, 16'd0));
        dir_rows.push_back(dir_entry(OP_TICK, 8'd0,   16'd0, 1'b1, ST_RAN,   16'd2, 1'b0, 16'd1));
        dir_rows.push_back(dir_entry(OP_TICK, 8'hFF,  16'hFFFF, 1'b1, ST_RAN, 16'd2, 1'b1, 16'd0));
        dir_rows.push_back(dir_entry(OP_TICK, 8'd0,   16'd0, 1'b1, ST_IDLE,  16'd0, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_ADD,  8'd7,   16'd1, 1'b1, ST_ADDED, 16'd3, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_ADD,  8'd7,   16'd1, 1'b1, ST_ADDED, 16'd4, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_ADD,  8'd3,   16'd2, 1'b1, ST_ADDED, 16'd5, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_TICK, 8'd0,   16'd0, 1'b0, ST_RAN,   16'd0, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_TICK, 8'd0,   16'd0, 1'b0, ST_RAN,   16'd0, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_TICK, 8'd0,   16'd0, 1'b0, ST_RAN,   16'd0, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_TICK, 8'd0,   16'd0, 1'b0, ST_RAN,   16'd0, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_TICK, 8'd0,   16'd0, 1'b1, ST_IDLE,  16'd0, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_ADD,  8'd0,   16'd1, 1'b1, ST_ADDED, 16'd6, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_ADD,  8'd255, 16'd3, 1'b0, ST_ADDED, 16'd0, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_TICK, 8'd0,   16'd0, 1'b1, ST_RAN,   16'd6, 1'b1, 16'd0));
        foreach (dir_rows[i])
            send_word(dir_rows[i].w, $urandom_range(0, 7), dir_rows[i].typed, dir_rows[i].res);

        // fill the table, then hit it with a full-width burst and a zero burst
        while (tasks_held() < TASK_SLOTS) begin
            w.opcode        = OP_ADD;
            w.task_priority = 8'($urandom_range(0, 255));
            w.task_burst    = 16'($urandom_range(1, 4));
            send_word(w, $urandom_range(0, 7), 1'b0, '0);
        end
        dir_rows.delete();
        dir_rows.push_back(dir_entry(OP_ADD, 8'd255, 16'hFFFF, 1'b1, ST_FULL, 16'd0, 1'b0, 16'd0));
        dir_rows.push_back(dir_entry(OP_ADD, 8'd0,   16'd0,    1'b1, ST_ZERO, 16'd0, 1'b0, 16'd0));
        foreach (dir_rows[i])
            send_word(dir_rows[i].w, $urandom_range(0, 7), dir_rows[i].typed, dir_rows[i].res);

        phase    = 0;
        next_cfg = 0;
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            if (n_random >= next_cfg) begin
                case (phase)
                    0:       set_aging(16'd1, 8'd0);
                    1:       set_aging(16'd0, 8'd0);
                    2:       set_aging(16'hFFFF, 8'hFF);
                    3:       set_aging(16'd2, 8'd100);
                    4:       set_aging(16'd0, 8'd7);
                    5:       set_aging(16'hFFFF, 8'd0);
                    6:       set_aging(16'd4, 8'd2);
                    default: set_aging(16'($urandom_range(1, 12)), 8'($urandom_range(0, 255)));
                endcase
                phase++;
                next_cfg += PHASE_ITEMS;
            end
            kind    = $urandom_range(0, 9);
            len     = $urandom_range(1, 20);
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            for (k = 0; k < len; k++) begin
                if (kind < 2 || (kind >= 5 && $urandom_range(0, 4) < 2)) begin
                    w = make_add();
                end else begin
                    w.opcode        = OP_TICK;
                    w.task_priority = 8'($urandom_range(0, 255));
                    w.task_burst    = 16'($urandom_range(0, 65535));
                end
                send_word(w, $urandom_range(0, gap_max), 1'b0, '0);
                n_random++;
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        k = 0;
        while (pending_results.size() != 0 && k < 1000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("words never delivered", 0, pending_results.size());

        $display("run covered %0d words over %0d aging settings: %0d added, %0d rejected full,",
                 n_sent, n_cfg + 1, n_added, n_full);
        $display("  %0d zero burst, %0d ticks ran (%0d finished), %0d idle, %0d priorities aged",
                 n_zero, n_ran, n_done, n_idle, n_aged);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/psa_pkg.sv
rtl/core/psa_slot_mem.sv
rtl/core/psa_alu.sv
rtl/core/psa_seq.sv
rtl/core/priority_scheduler_with_aging.sv
dv/priority_scheduler_with_aging_tb.sv
